// File: hw/rtl/stl_pkg.sv
// Shared types, character codes and sizes for the source text lexer.
package stl_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LENGTH_BITS   = 16;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // result queue sizing: room for one worst-case byte (three tokens) is
    // checked before each push
    localparam int Q_DEPTH     = 8;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_APOS       = 8'h27;
    localparam logic [7:0] CH_LOW_I      = 8'h69;
    localparam logic [7:0] CH_LOW_F      = 8'h66;
    localparam logic [7:0] CH_LOW_E      = 8'h65;
    localparam logic [7:0] CH_LOW_L      = 8'h6C;
    localparam logic [7:0] CH_LOW_S      = 8'h73;

    typedef enum logic [3:0] {
        KIND_CONSTANT  = 4'd0,
        KIND_IDENT     = 4'd1,
        KIND_KEYWORD   = 4'd2,
        KIND_STR_OPEN  = 4'd3,
        KIND_STR_BODY  = 4'd4,
        KIND_STR_CLOSE = 4'd5,
        KIND_CHR_OPEN  = 4'd6,
        KIND_CHR_CLOSE = 4'd7,
        KIND_UNTERM    = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [POSITION_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0]   length;
        logic                     clipped;
        logic                     last;
    } stl_token_t;

    // tokens produced by one byte, slot 0 first
    typedef struct packed {
        logic [1:0]                   count;
        stl_token_t [MAX_RESULTS-1:0] tok;
    } stl_push_t;

endpackage

// File: hw/rtl/source_text_lexer.sv
// Top level of the streaming source text lexer.
//
// Usage:
//   Slave side carries source text, one byte per request: s_tdata[7:0] is
//   the byte, s_tlast marks the last byte of a text. Master side carries
//   token requests: m_tuser is the token kind, m_tdata holds start offset,
//   length and the length-clipped flag, m_tlast marks the final token
//   caused by one input byte.
//   Path: a byte in the input register is decoded by stl_core once the
//   queue has room; its tokens go to the queue memory, then to the head
//   register that drives the master side. Throughput: one byte per cycle
//   while the queue has room; decode is one pass through the mode logic
//   in stl_core for any mode. The output side moves one token per cycle
//   while m_tready is high; a byte's extra tokens wait in the eight-entry queue.
//   Stall: while the queue lacks room for three tokens the held byte waits
//   in the input register and s_tready drops; nothing is lost or repeated.
//   Reset: synchronous, active low; clears the lexer to the start of a
//   text (offset 0, idle) and empties the queue. After a byte with s_tlast
//   the lexer returns to the same state on its own.
module source_text_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] token_offset, [47:32] token_length,
                                   // [48] length_clipped, [55:49] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import stl_pkg::*;

    // input register: one byte request waiting for decode
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       space;
    logic       step;
    stl_push_t  push;
    stl_token_t head;

    // decode fires when a byte is held and the queue can take its worst case
    assign step     = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    stl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .byte_i  (in_byte_reg),
        .last_i  (in_last_reg),
        .push_o  (push)
    );

    stl_result_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (push),
        .space_o      (space),
        .head_o       (head),
        .head_valid_o (m_tvalid),
        .pop_i        (m_tready)
    );

    assign m_tdata = {7'b0, head.clipped, head.length, head.offset};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// File: hw/rtl/stl_core.sv
// Lexer state and per-byte token decision logic.
module stl_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_i,
    input  logic [7:0]        byte_i,
    input  logic              last_i,
    output stl_pkg::stl_push_t push_o
);
    import stl_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE       = 6'b000001,
        MODE_WORD       = 6'b000010,
        MODE_NUMBER     = 6'b000100,
        MODE_STRING     = 6'b001000,
        MODE_CHAR_CONST = 6'b010000,
        MODE_CHAR_CLOSE = 6'b100000
    } mode_t;

    // keyword match progress
    localparam logic [2:0] KP_NONE = 3'd0;
    localparam logic [2:0] KP_I    = 3'd1;
    localparam logic [2:0] KP_IF   = 3'd2;
    localparam logic [2:0] KP_E    = 3'd3;
    localparam logic [2:0] KP_EL   = 3'd4;
    localparam logic [2:0] KP_ELS  = 3'd5;
    localparam logic [2:0] KP_ELSE = 3'd6;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic                     clip_reg, clip_next;
    logic [2:0]               kp_reg, kp_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [1:0]               n;
    logic                     redo;
    logic                     is_letter, is_digit;
    kind_t                    word_kind;

    function automatic stl_token_t mk_tok(kind_t k, logic [POSITION_BITS-1:0] off,
                                          logic [LENGTH_BITS-1:0] len, logic clip);
        stl_token_t t;
        t.kind    = k;
        t.offset  = off;
        t.length  = len;
        t.clipped = clip;
        t.last    = 1'b0;
        return t;
    endfunction

    function automatic logic [2:0] kw_step(logic [2:0] kp, logic [7:0] b);
        logic [2:0] r;
        r = KP_NONE;
        if (kp == KP_I && b == CH_LOW_F) r = KP_IF;
        if (kp == KP_E && b == CH_LOW_L) r = KP_EL;
        if (kp == KP_EL && b == CH_LOW_S) r = KP_ELS;
        if (kp == KP_ELS && b == CH_LOW_E) r = KP_ELSE;
        return r;
    endfunction

    assign is_letter = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                       (byte_i >= 8'h41 && byte_i <= 8'h5A) || byte_i == CH_UNDERSCORE;
    assign is_digit  = byte_i >= 8'h30 && byte_i <= 8'h39;
    assign word_kind = (kp_reg == KP_IF || kp_reg == KP_ELSE) ? KIND_KEYWORD : KIND_IDENT;

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        clip_next  = clip_reg;
        kp_next    = kp_reg;
        pos_next   = pos_reg;
        n          = 2'd0;
        redo       = 1'b0;
        push_o     = '0;

        unique case (mode_reg)
            MODE_WORD: begin
                if (is_letter || is_digit) begin
                    kp_next = kw_step(kp_reg, byte_i);
                    if (len_reg == LEN_MAX) clip_next = 1'b1;
                    else len_next = len_reg + LENGTH_BITS'(1);
                end else begin
                    push_o.tok[n] = mk_tok(word_kind, start_reg, len_reg, clip_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit || byte_i == CH_DOT) begin
                    if (len_reg == LEN_MAX) clip_next = 1'b1;
                    else len_next = len_reg + LENGTH_BITS'(1);
                end else begin
                    push_o.tok[n] = mk_tok(KIND_CONSTANT, start_reg, len_reg, clip_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            MODE_STRING: begin
                if (byte_i == CH_QUOTE) begin
                    push_o.tok[n] = mk_tok(KIND_STR_BODY, start_reg, len_reg, clip_reg);
                    n = n + 2'd1;
                    push_o.tok[n] = mk_tok(KIND_STR_CLOSE, pos_reg, LENGTH_BITS'(1), 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end else begin
                    if (len_reg == LEN_MAX) clip_next = 1'b1;
                    else len_next = len_reg + LENGTH_BITS'(1);
                end
            end
            MODE_CHAR_CONST: begin
                push_o.tok[n] = mk_tok(KIND_CONSTANT, pos_reg, LENGTH_BITS'(1), 1'b0);
                n = n + 2'd1;
                if (len_reg == LEN_MAX) clip_next = 1'b1;
                else len_next = len_reg + LENGTH_BITS'(1);
                mode_next = MODE_CHAR_CLOSE;
            end
            MODE_CHAR_CLOSE: begin
                push_o.tok[n] = mk_tok(KIND_CHR_CLOSE, pos_reg, LENGTH_BITS'(1), 1'b0);
                n = n + 2'd1;
                mode_next = MODE_IDLE;
            end
            default: redo = 1'b1;
        endcase

        // byte that ended a run, or any byte while idle, starts fresh
        if (redo) begin
            mode_next = MODE_IDLE;
            if (is_letter) begin
                mode_next  = MODE_WORD;
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
                clip_next  = 1'b0;
                kp_next    = (byte_i == CH_LOW_I) ? KP_I :
                             (byte_i == CH_LOW_E) ? KP_E : KP_NONE;
            end else if (is_digit || byte_i == CH_DOT) begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
                clip_next  = 1'b0;
                kp_next    = KP_NONE;
            end else if (byte_i == CH_QUOTE || byte_i == CH_APOS) begin
                push_o.tok[n] = mk_tok((byte_i == CH_QUOTE) ? KIND_STR_OPEN : KIND_CHR_OPEN,
                                       pos_reg, LENGTH_BITS'(1), 1'b0);
                n = n + 2'd1;
                mode_next  = (byte_i == CH_QUOTE) ? MODE_STRING : MODE_CHAR_CONST;
                start_next = pos_reg + POSITION_BITS'(1);
                len_next   = '0;
                clip_next  = 1'b0;
                kp_next    = KP_NONE;
            end
        end

        if (last_i) begin
            // flush whatever is pending, then back to the start of a new text
            if (mode_next == MODE_WORD) begin
                push_o.tok[n] = mk_tok((kp_next == KP_IF || kp_next == KP_ELSE) ?
                                       KIND_KEYWORD : KIND_IDENT,
                                       start_next, len_next, clip_next);
                n = n + 2'd1;
            end else if (mode_next == MODE_NUMBER) begin
                push_o.tok[n] = mk_tok(KIND_CONSTANT, start_next, len_next, clip_next);
                n = n + 2'd1;
            end else if (mode_next != MODE_IDLE) begin
                push_o.tok[n] = mk_tok(KIND_UNTERM, start_next, len_next, clip_next);
                n = n + 2'd1;
            end
            mode_next  = MODE_IDLE;
            start_next = '0;
            len_next   = '0;
            clip_next  = 1'b0;
            kp_next    = KP_NONE;
            pos_next   = '0;
        end else begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end

        if (n != 2'd0) push_o.tok[n - 2'd1].last = 1'b1;
        push_o.count = step_i ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            clip_reg  <= 1'b0;
            kp_reg    <= KP_NONE;
            pos_reg   <= '0;
        end else if (step_i) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            clip_reg  <= clip_next;
            kp_reg    <= kp_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: hw/rtl/stl_result_queue.sv
// Token queue: takes up to three tokens per cycle, hands out one from a head register.
module stl_result_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  stl_pkg::stl_push_t  push_i,
    output logic                space_o,
    output stl_pkg::stl_token_t head_o,
    output logic                head_valid_o,
    input  logic                pop_i
);
    import stl_pkg::*;

    stl_token_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    stl_token_t         head_reg;
    logic               head_valid_reg;
    logic               load;

    assign load       = (count_reg != '0) && (!head_valid_reg || pop_i);
    assign count_next = count_reg + Q_CNT_W'(push_i.count) - Q_CNT_W'(load);
    assign space_o    = count_reg <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (push_i.count > 2'(k)) mem[wr_ptr_reg + Q_PTR_W'(k)] <= push_i.tok[k];
        end
        if (load) head_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push_i.count);
            if (load) rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
            if (load) head_valid_reg <= 1'b1;
            else if (pop_i) head_valid_reg <= 1'b0;
        end
    end

    assign head_o       = head_reg;
    assign head_valid_o = head_valid_reg;

endmodule

// File: hw/rtl/stl_checker.sv
// Port-level checks for the source text lexer, bound to the top level.
module stl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import stl_pkg::*;

    logic single_kind;
    assign single_kind = m_tuser == KIND_STR_OPEN || m_tuser == KIND_STR_CLOSE ||
                         m_tuser == KIND_CHR_OPEN || m_tuser == KIND_CHR_CLOSE;

    // stalled token request stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("token request dropped while stalled");

    // string and character open/close tokens are one byte, never clipped
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && single_kind |-> m_tdata[47:32] == 16'd1 && !m_tdata[48])
        else $error("single-byte token with wrong length");

    // unterminated token is always the final one of its byte
    a_unterm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_UNTERM |-> m_tlast)
        else $error("unterminated token not last of run");

    // reset leaves no token pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("token valid right after reset");

endmodule

bind source_text_lexer stl_checker u_stl_checker (.*);

// File: verif/stl_token_checker.sv
// Token checker for the source text lexer: predicts token requests and compares them.
module stl_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          tokens_checked,
    output int          clipped_checked
);
    import stl_pkg::*;

    localparam int OFF_LO  = 0;
    localparam int LEN_LO  = POSITION_BITS;
    localparam int CLIP_AT = POSITION_BITS + LENGTH_BITS;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_WORD,
        LX_NUMBER,
        LX_STRING,
        LX_CHAR_CONST,
        LX_CHAR_CLOSE
    } lex_mode_t;

    // how much of "if" / "else" the current word has matched
    typedef enum logic [2:0] {
        KW_NONE,
        KW_I,
        KW_IF,
        KW_E,
        KW_EL,
        KW_ELS,
        KW_ELSE
    } kw_prog_t;

    lex_mode_t                mode;
    kw_prog_t                 kw;
    logic [POSITION_BITS-1:0] run_start;
    logic [POSITION_BITS-1:0] byte_pos;
    logic [LENGTH_BITS-1:0]   run_len;
    logic                     run_clip;

    stl_token_t expected_tokens[$];
    stl_token_t step_tokens[$];
    int         fails     = 0;
    int         checked   = 0;
    int         clipped_n = 0;

    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic kw_prog_t kw_step(input kw_prog_t prog, input logic [7:0] b);
        case (prog)
            KW_I:    return (b == CH_LOW_F) ? KW_IF : KW_NONE;
            KW_E:    return (b == CH_LOW_L) ? KW_EL : KW_NONE;
            KW_EL:   return (b == CH_LOW_S) ? KW_ELS : KW_NONE;
            KW_ELS:  return (b == CH_LOW_E) ? KW_ELSE : KW_NONE;
            default: return KW_NONE;
        endcase
    endfunction

    task automatic add_token(input kind_t k, input logic [POSITION_BITS-1:0] off,
                             input logic [LENGTH_BITS-1:0] len, input logic clip);
        stl_token_t t;
        t.kind    = k;
        t.offset  = off;
        t.length  = len;
        t.clipped = clip;
        t.last    = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endtask

    task automatic reset_lexer();
        mode      = LX_IDLE;
        kw        = KW_NONE;
        run_start = '0;
        byte_pos  = '0;
        run_len   = '0;
        run_clip  = 1'b0;
    endtask

    task automatic begin_run(input lex_mode_t m, input logic [POSITION_BITS-1:0] off,
                             input logic [LENGTH_BITS-1:0] len);
        mode      = m;
        run_start = off;
        run_len   = len;
        run_clip  = 1'b0;
        kw        = KW_NONE;
    endtask

    task automatic extend_run();
        if (run_len == LEN_MAX)
            run_clip = 1'b1;
        else
            run_len = run_len + 1'b1;
    endtask

    task automatic flush_word();
        if (kw == KW_IF || kw == KW_ELSE)
            add_token(KIND_KEYWORD, run_start, run_len, run_clip);
        else
            add_token(KIND_IDENT, run_start, run_len, run_clip);
    endtask

    task automatic start_from_idle(input logic [7:0] b, input logic [POSITION_BITS-1:0] p);
        mode = LX_IDLE;
        if (is_name_char(b)) begin
            begin_run(LX_WORD, p, LENGTH_BITS'(1));
            kw = (b == CH_LOW_I) ? KW_I : (b == CH_LOW_E) ? KW_E : KW_NONE;
        end else if (is_digit(b) || b == CH_DOT) begin
            begin_run(LX_NUMBER, p, LENGTH_BITS'(1));
        end else if (b == CH_QUOTE) begin
            add_token(KIND_STR_OPEN, p, LENGTH_BITS'(1), 1'b0);
            begin_run(LX_STRING, p + 1'b1, '0);
        end else if (b == CH_APOS) begin
            add_token(KIND_CHR_OPEN, p, LENGTH_BITS'(1), 1'b0);
            begin_run(LX_CHAR_CONST, p + 1'b1, '0);
        end
    endtask

    // one accepted text byte: advance the lexer and queue the tokens it causes
    task automatic lex_byte(input logic [7:0] b, input logic eot);
        logic [POSITION_BITS-1:0] p;
        stl_token_t               t;
        p = byte_pos;
        step_tokens.delete();
        case (mode)
            LX_WORD: begin
                if (is_name_char(b) || is_digit(b)) begin
                    kw = kw_step(kw, b);
                    extend_run();
                end else begin
                    flush_word();
                    start_from_idle(b, p);
                end
            end
            LX_NUMBER: begin
                if (is_digit(b) || b == CH_DOT) begin
                    extend_run();
                end else begin
                    add_token(KIND_CONSTANT, run_start, run_len, run_clip);
                    start_from_idle(b, p);
                end
            end
            LX_STRING: begin
                if (b == CH_QUOTE) begin
                    add_token(KIND_STR_BODY, run_start, run_len, run_clip);
                    add_token(KIND_STR_CLOSE, p, LENGTH_BITS'(1), 1'b0);
                    mode = LX_IDLE;
                end else begin
                    extend_run();
                end
            end
            LX_CHAR_CONST: begin
                add_token(KIND_CONSTANT, p, LENGTH_BITS'(1), 1'b0);
                extend_run();
                mode = LX_CHAR_CLOSE;
            end
            LX_CHAR_CLOSE: begin
                add_token(KIND_CHR_CLOSE, p, LENGTH_BITS'(1), 1'b0);
                mode = LX_IDLE;
            end
            default: start_from_idle(b, p);
        endcase

        if (eot) begin
            if (mode == LX_WORD)
                flush_word();
            else if (mode == LX_NUMBER)
                add_token(KIND_CONSTANT, run_start, run_len, run_clip);
            else if (mode != LX_IDLE)
                add_token(KIND_UNTERM, run_start, run_len, run_clip);
            reset_lexer();
        end else begin
            byte_pos = p + 1'b1;
        end

        for (int i = 0; i < step_tokens.size(); i++) begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endtask

    task automatic check_token();
        stl_token_t want;
        if (expected_tokens.size() == 0) begin
            $error("unexpected token request: kind %0d offset %0d length %0d",
                   m_tuser, m_tdata[LEN_LO-1:OFF_LO], m_tdata[CLIP_AT-1:LEN_LO]);
            fails++;
        end else begin
            want = expected_tokens.pop_front();
            checked++;
            if (want.clipped)
                clipped_n++;
            if (m_tuser !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, m_tuser);
                fails++;
            end
            if (m_tdata[LEN_LO-1:OFF_LO] !== want.offset) begin
                $error("token_offset: expected %0d, got %0d", want.offset,
                       m_tdata[LEN_LO-1:OFF_LO]);
                fails++;
            end
            if (m_tdata[CLIP_AT-1:LEN_LO] !== want.length) begin
                $error("token_length: expected %0d, got %0d", want.length,
                       m_tdata[CLIP_AT-1:LEN_LO]);
                fails++;
            end
            if (m_tdata[CLIP_AT] !== want.clipped) begin
                $error("length_clipped: expected %0d, got %0d", want.clipped, m_tdata[CLIP_AT]);
                fails++;
            end
            if (m_tdata[55:CLIP_AT+1] !== '0) begin
                $error("m_tdata padding: expected 0, got %0h", m_tdata[55:CLIP_AT+1]);
                fails++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                fails++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_lexer();
            expected_tokens.delete();
        end else begin
            // outputs first: a byte taken at this edge cannot show up yet
            if (m_tvalid && m_tready)
                check_token();
            if (s_tvalid && s_tready)
                lex_byte(s_tdata, s_tlast);
        end
        fail_count      <= fails;
        pending         <= expected_tokens.size();
        tokens_checked  <= checked;
        clipped_checked <= clipped_n;
    end

endmodule

// File: verif/tb_source_text_lexer.sv
// Testbench top for the source text lexer: stimulus, idling and verdict.
module tb_source_text_lexer;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 480;
    // no idling on either side for the final stretch of random text
    localparam int CALM_TAIL    = 60;
    // trailing cycles after the last token, as slack
    localparam int DRAIN_WAIT   = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int tokens_checked;
    int clipped_checked;

    int cycles     = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    // 0 means no idling; otherwise roughly one burst per that many requests
    int gap_odds   = 0;
    int stall_odds = 0;

    // first 53 characters can start a word, all 63 can continue one
    string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string num_chars  = "0123456789.";
    string sep_chars  = " \n\t(;+,=";
    // words that only almost match a keyword, plus case variants
    string near_kw[8] = '{"i", "e", "el", "els", "iff", "elsex", "If", "ELSE"};

    logic [7:0] text_buf[$];

    source_text_lexer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stl_token_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .tokens_checked  (tokens_checked),
        .clipped_checked (clipped_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk)
        cycles <= cycles + 1;

    // hard stop in case a request is never taken or a token never shows up
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("FAIL source_text_lexer");
        $finish;
    end

    // token side: random stall bursts while stall_odds is set
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // One text byte request. Called at a rising edge; returns at the edge
    // where the byte was taken. s_tvalid stays high between back-to-back
    // requests, so it is never lowered and raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int n;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (eot)
            texts_sent++;
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] any_but_quote();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_QUOTE) ? CH_APOS : b;
    endfunction

    // Mostly well-formed lexemes with random content, glued together with
    // or without separators (so word/number ends get reprocessed), plus
    // raw noise. A quarter of the texts are cut short at a random byte,
    // which lands the end of text inside words, numbers and literals.
    task automatic build_random_text();
        int pieces;
        int cut;
        text_buf.delete();
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0: push_str($urandom_range(0, 1) ? "if" : "else");
                1: push_str(near_kw[$urandom_range(0, 7)]);
                2: begin
                    add_byte(name_chars[$urandom_range(0, 52)]);
                    repeat ($urandom_range(0, 6))
                        add_byte(name_chars[$urandom_range(0, 62)]);
                end
                3: begin
                    repeat ($urandom_range(1, 6))
                        add_byte(num_chars[$urandom_range(0, 10)]);
                end
                4: begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                        add_byte(any_but_quote());
                    // an occasional missing close quote swallows what follows
                    if ($urandom_range(0, 7) != 0)
                        add_byte(CH_QUOTE);
                end
                5: begin
                    add_byte(CH_APOS);
                    add_byte(8'($urandom_range(0, 255)));
                    // the close position takes any byte, not just an apostrophe
                    if ($urandom_range(0, 3) != 0)
                        add_byte(CH_APOS);
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
                6, 7: add_byte(sep_chars[$urandom_range(0, 7)]);
                default: begin
                    repeat ($urandom_range(1, 3))
                        add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
        if (text_buf.size() > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, text_buf.size());
            text_buf = text_buf[0:cut-1];
        end
    endtask

    initial begin
        int random_base;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts, light idling on both sides.
        gap_odds   = 4;
        stall_odds = 4;
        // keyword, near-keyword identifier, word flushed by a quote that is
        // also the last byte: identifier, string open and unterminated token
        send_text("if+els3 x\"", 1'b1);
        // keyword flushed at end of text
        send_text("else", 1'b1);
        // number ended by a letter, word ended by a quote, string body with
        // a zero byte, empty string, character literal holding 0xFF
        send_text("1.2a\"b", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"\"\"'", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("'", 1'b0);
        // number flushed at end of text
        send_text(".5", 1'b1);
        // character literal cut off right after its open
        send_text("'", 1'b1);

        // Random texts; each picks its own idling level, some with none.
        random_base = bytes_sent;
        while (bytes_sent - random_base < RANDOM_BYTES) begin
            if (bytes_sent - random_base >= RANDOM_BYTES - CALM_TAIL) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    2:       gap_odds = 8;
                    default: gap_odds = 20;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    2:       stall_odds = 8;
                    default: stall_odds = 20;
                endcase
            end
            build_random_text();
            for (int i = 0; i < text_buf.size(); i++)
                send_byte(text_buf[i], i == text_buf.size() - 1);
        end

        // Drain: the checker's count is a registered copy of its queue size.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Lexed %0d bytes in %0d texts: directed cases and random texts",
                 bytes_sent, texts_sent);
        $display("under random idling; %0d tokens compared, %0d of them with clipped length.",
                 tokens_checked, clipped_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS source_text_lexer");
        end else begin
            $display("FAIL source_text_lexer");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/stl_pkg.sv
hw/rtl/stl_core.sv
hw/rtl/stl_result_queue.sv
hw/rtl/source_text_lexer.sv
hw/rtl/stl_checker.sv
verif/stl_token_checker.sv
verif/tb_source_text_lexer.sv
